// ===== rtl/lsrgu_pkg.sv =====
// Package for the level-set reinitialization Godunov update block.
// Types, constants and helper functions shared by the interfaces and modules.
// No dependencies.
`timescale 1ns / 1ps

package lsrgu_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned RAD_W      = 2 * VAL_W;
	localparam int unsigned ROOT_W     = VAL_W;
	localparam int unsigned SQRT_STEPS = ROOT_W;
	localparam int unsigned REM_W      = ROOT_W + 1;
	localparam int unsigned PROD_W     = CFG_W + VAL_W;
	localparam int unsigned RES_W      = VAL_W + 3;

	localparam logic [ROOT_W-1:0] Q_ONE      = ROOT_W'(65536);
	localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(32768);

	localparam logic [CFG_W-1:0] TIME_STEP_RST = CFG_W'(655);
	localparam logic [CFG_W-1:0] SIGN_BAND_RST = CFG_W'(7);

	typedef enum logic [0:0] {
		CFG_TIME_STEP = 1'b0,
		CFG_SIGN_BAND = 1'b1
	} cfg_idx_t;

	// Fields that ride alongside the radicand through the root pipeline.
	typedef struct packed {
		logic signed [VAL_W-1:0] cur;
		logic                    active;
		logic                    pos;
	} side_t;

	// Magnitude of the positive part (keep_pos) or of the negative part of v.
	function automatic logic [VAL_W-1:0] part_mag(input logic signed [VAL_W-1:0] v,
			input logic keep_pos);
		logic [VAL_W-1:0] r;
		r = '0;
		if (keep_pos) begin
			if (v > 0)
				r = VAL_W'(v);
		end else begin
			if (v < 0)
				r = VAL_W'(-v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/lsrgu_ifs.sv =====
// Channel interfaces for the level-set Godunov update block.
// Depends on lsrgu_pkg.
`timescale 1ns / 1ps

interface lsrgu_pt_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lsrgu_pkg::VAL_W-1:0]   ref_level;
	logic signed [lsrgu_pkg::VAL_W-1:0]   cur_level;
	logic signed [lsrgu_pkg::VAL_W-1:0]   fwd_diff_x;
	logic signed [lsrgu_pkg::VAL_W-1:0]   back_diff_x;
	logic signed [lsrgu_pkg::VAL_W-1:0]   fwd_diff_y;
	logic signed [lsrgu_pkg::VAL_W-1:0]   back_diff_y;

	modport source (output valid, ref_level, cur_level, fwd_diff_x, back_diff_x,
		fwd_diff_y, back_diff_y, input ready);
	modport sink (input valid, ref_level, cur_level, fwd_diff_x, back_diff_x,
		fwd_diff_y, back_diff_y, output ready);
endinterface

interface lsrgu_upd_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lsrgu_pkg::VAL_W-1:0]   new_level;
	logic                                 saturated;

	modport source (output valid, new_level, saturated, input ready);
	modport sink (input valid, new_level, saturated, output ready);
endinterface

interface lsrgu_cfg_if;
	logic                            valid;
	logic                            ready;
	lsrgu_pkg::cfg_idx_t             index;
	logic [lsrgu_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lsrgu_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
// Carries a side_t record per request. Depends on lsrgu_pkg.
`timescale 1ns / 1ps

module lsrgu_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lsrgu_pkg::RAD_W-1:0]       in_rad,
	input  lsrgu_pkg::side_t                  in_side,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lsrgu_pkg::ROOT_W-1:0]      out_root,
	output lsrgu_pkg::side_t                  out_side
);

	localparam int unsigned N = lsrgu_pkg::SQRT_STEPS;

	logic [N-1:0]                          v_s;
	logic [N-1:0]                          ld;
	logic [lsrgu_pkg::REM_W-1:0]           rem_s  [0:N-1];
	logic [lsrgu_pkg::ROOT_W-1:0]          root_s [0:N-1];
	logic [lsrgu_pkg::RAD_W-1:0]           x_s    [0:N-2];
	lsrgu_pkg::side_t                      side_s [0:N-1];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [lsrgu_pkg::REM_W-1:0]   rem_p;
		logic [lsrgu_pkg::ROOT_W-1:0]  root_p;
		logic [lsrgu_pkg::RAD_W-1:0]   x_p;
		lsrgu_pkg::side_t              side_p;
		logic                          v_p;
		logic                          rdy_n;
		logic [lsrgu_pkg::REM_W+1:0]   rem_sh;
		logic [lsrgu_pkg::REM_W+1:0]   trial;
		logic                          ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign x_p    = in_rad;
			assign side_p = in_side;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign x_p    = x_s[k-1];
			assign side_p = side_s[k-1];
			assign v_p    = v_s[k-1];
		end

		if (k == N - 1) begin : g_rlast
			assign rdy_n = out_ready;
		end else begin : g_rmid
			assign rdy_n = ld[k+1];
		end

		assign ld[k]  = !v_s[k] || rdy_n;
		assign rem_sh = {rem_p, x_p[lsrgu_pkg::RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_p, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (ld[k])
				v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rem_s[k]  <= ge ? lsrgu_pkg::REM_W'(rem_sh - trial)
					: lsrgu_pkg::REM_W'(rem_sh);
				root_s[k] <= {root_p[lsrgu_pkg::ROOT_W-2:0], ge};
				side_s[k] <= side_p;
			end
		end

		if (k < N - 1) begin : g_x
			always_ff @(posedge clk) begin
				if (ld[k])
					x_s[k] <= {x_p[lsrgu_pkg::RAD_W-3:0], 2'b00};
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

// ===== rtl/level_set_reinit_godunov_update.sv =====
// Top level of the level-set reinitialization Godunov update block.
// Depends on lsrgu_pkg, lsrgu_ifs (channel interfaces) and lsrgu_isqrt.
//
// Usage:
//   pt   : input requests, one grid point each (reference value, current value
//          and the four one-sided differences, signed Q16.16).
//   upd  : result requests, the updated value and a saturation flag.
//   cfg  : register writes, index 0 time_step, index 1 sign_band; always ready.
//          Write only while no request is in flight.
//   An accepted point passes to its result through four stages that select
//   the upwind parts, square, take maxima and sum; 32 stages of the square
//   root, one root bit each; five stages for the step term, rounding and the
//   saturating update. Throughput is one point per cycle unless upd stalls.
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it moves, so bubbles close up and pt stays ready while a
//   finished result waits on upd as long as some stage is empty; once all
//   41 stages hold requests, pt.ready follows upd.ready. Nothing is lost or
//   repeated under stall.
//   Reset clears all valid bits and loads the register reset values
//   (time_step 655, sign_band 7).
`timescale 1ns / 1ps

module level_set_reinit_godunov_update (
	input  logic          clk,
	input  logic          arst_n,
	lsrgu_pt_if.sink      pt,
	lsrgu_upd_if.source   upd,
	lsrgu_cfg_if.sink     cfg
);

	localparam int unsigned VW = lsrgu_pkg::VAL_W;

	logic [lsrgu_pkg::CFG_W-1:0] time_step_q;
	logic [lsrgu_pkg::CFG_W-1:0] sign_band_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= lsrgu_pkg::TIME_STEP_RST;
			sign_band_q <= lsrgu_pkg::SIGN_BAND_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				lsrgu_pkg::CFG_TIME_STEP: time_step_q <= cfg.data;
				lsrgu_pkg::CFG_SIGN_BAND: sign_band_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9;
	logic sq_in_ready, sq_out_valid;

	assign ld9 = !v_s9 || upd.ready;
	assign ld8 = !v_s8 || ld9;
	assign ld7 = !v_s7 || ld8;
	assign ld6 = !v_s6 || ld7;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || sq_in_ready;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign pt.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= pt.valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= sq_out_valid;
			if (ld6) v_s6 <= v_s5;
			if (ld7) v_s7 <= v_s6;
			if (ld8) v_s8 <= v_s7;
			if (ld9) v_s9 <= v_s8;
		end
	end

	// s1: dead band test and upwind part magnitudes
	logic signed [VW:0] ref_x, band_x;
	logic               pos_c, neg_c;

	assign ref_x  = (VW + 1)'(pt.ref_level);
	assign band_x = $signed({{(VW + 1 - lsrgu_pkg::CFG_W){1'b0}}, sign_band_q});
	assign pos_c  = ref_x > band_x;
	assign neg_c  = ref_x < -band_x;

	logic [VW-1:0]    a_s1, b_s1, c_s1, d_s1;
	lsrgu_pkg::side_t side_s1, side_s2, side_s3, side_s4;

	always_ff @(posedge clk) begin
		if (ld1) begin
			a_s1 <= lsrgu_pkg::part_mag(pt.back_diff_x, !pos_c);
			b_s1 <= lsrgu_pkg::part_mag(pt.fwd_diff_x, pos_c);
			c_s1 <= lsrgu_pkg::part_mag(pt.back_diff_y, !pos_c);
			d_s1 <= lsrgu_pkg::part_mag(pt.fwd_diff_y, pos_c);
			side_s1.cur    <= pt.cur_level;
			side_s1.active <= pos_c || neg_c;
			side_s1.pos    <= pos_c;
		end
	end

	// s2: squares, exact Q32.32
	logic [lsrgu_pkg::RAD_W-1:0] sa_s2, sb_s2, sc_s2, sd_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			sa_s2   <= a_s1 * a_s1;
			sb_s2   <= b_s1 * b_s1;
			sc_s2   <= c_s1 * c_s1;
			sd_s2   <= d_s1 * d_s1;
			side_s2 <= side_s1;
		end
	end

	// s3: maxima
	logic [lsrgu_pkg::RAD_W-1:0] mx_s3, my_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			mx_s3   <= (sa_s2 > sb_s2) ? sa_s2 : sb_s2;
			my_s3   <= (sc_s2 > sd_s2) ? sc_s2 : sd_s2;
			side_s3 <= side_s2;
		end
	end

	// s4: radicand, at most 2^63
	logic [lsrgu_pkg::RAD_W-1:0] rad_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			rad_s4  <= mx_s3 + my_s3;
			side_s4 <= side_s3;
		end
	end

	logic [lsrgu_pkg::ROOT_W-1:0] sq_root;
	lsrgu_pkg::side_t             sq_side;

	lsrgu_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (sq_in_ready),
		.in_rad    (rad_s4),
		.in_side   (side_s4),
		.out_valid (sq_out_valid),
		.out_ready (ld5),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// s5: |H| and sign of H
	logic [lsrgu_pkg::ROOT_W-1:0] mag_s5;
	logic                         hneg_s5;
	lsrgu_pkg::side_t             side_s5, side_s6, side_s7;
	logic                         hneg_s6, hneg_s7;

	always_ff @(posedge clk) begin
		if (ld5) begin
			hneg_s5 <= sq_root < lsrgu_pkg::Q_ONE;
			mag_s5  <= (sq_root < lsrgu_pkg::Q_ONE) ? lsrgu_pkg::Q_ONE - sq_root
				: sq_root - lsrgu_pkg::Q_ONE;
			side_s5 <= sq_side;
		end
	end

	// s6: dt * |H|, Q16.32
	logic [lsrgu_pkg::PROD_W-1:0] prod_s6;

	always_ff @(posedge clk) begin
		if (ld6) begin
			prod_s6 <= time_step_q * mag_s5;
			hneg_s6 <= hneg_s5;
			side_s6 <= side_s5;
		end
	end

	// s7: round to Q16.16, ties away from zero on the magnitude
	logic [lsrgu_pkg::PROD_W:0]    rnd;
	logic [lsrgu_pkg::ROOT_W-1:0]  term_s7;

	assign rnd = {1'b0, prod_s6} + lsrgu_pkg::ROUND_HALF;

	always_ff @(posedge clk) begin
		if (ld7) begin
			term_s7 <= side_s6.active ? rnd[lsrgu_pkg::PROD_W-1 -: lsrgu_pkg::ROOT_W] : '0;
			hneg_s7 <= hneg_s6;
			side_s7 <= side_s6;
		end
	end

	// s8: signed update at full width
	logic signed [lsrgu_pkg::RES_W-1:0] cur_x, term_x, res_s8;

	assign cur_x  = lsrgu_pkg::RES_W'(side_s7.cur);
	assign term_x = $signed({{(lsrgu_pkg::RES_W - lsrgu_pkg::ROOT_W){1'b0}}, term_s7});

	always_ff @(posedge clk) begin
		if (ld8) begin
			res_s8 <= (side_s7.pos ^ hneg_s7) ? cur_x - term_x : cur_x + term_x;
		end
	end

	// s9: saturate into the output register
	logic signed [VW-1:0] new_level_s9;
	logic                 sat_s9;
	logic                 over, under;

	assign over  = !res_s8[lsrgu_pkg::RES_W-1] && (res_s8[lsrgu_pkg::RES_W-2:VW-1] != '0);
	assign under = res_s8[lsrgu_pkg::RES_W-1] && (res_s8[lsrgu_pkg::RES_W-2:VW-1] != '1);

	always_ff @(posedge clk) begin
		if (ld9) begin
			sat_s9 <= over || under;
			if (over)
				new_level_s9 <= {1'b0, {(VW - 1){1'b1}}};
			else if (under)
				new_level_s9 <= {1'b1, {(VW - 1){1'b0}}};
			else
				new_level_s9 <= res_s8[VW-1:0];
		end
	end

	assign upd.valid     = v_s9;
	assign upd.new_level = new_level_s9;
	assign upd.saturated = sat_s9;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for level_set_reinit_godunov_update: drives grid points through the pt channel,
// predicts each Godunov upwind update in place and checks every result on upd.
// Depends on lsrgu_pkg, lsrgu_ifs and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic signed [31:0] FIELD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FIELD_MIN = 32'sh8000_0000;
	localparam longint SAT_HI = 64'sh7FFF_FFFF;
	localparam longint SAT_LO = -64'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] ref_level;
		logic signed [31:0] cur_level;
		logic signed [31:0] fwd_diff_x;
		logic signed [31:0] back_diff_x;
		logic signed [31:0] fwd_diff_y;
		logic signed [31:0] back_diff_y;
	} point_t;

	typedef struct packed {
		logic signed [31:0] new_level;
		logic               saturated;
	} update_t;

	logic clk = 1'b0;
	logic arst_n;

	lsrgu_pt_if  pt_ch ();
	lsrgu_upd_if upd_ch ();
	lsrgu_cfg_if cfg_ch ();

	level_set_reinit_godunov_update i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt_ch),
		.upd    (upd_ch),
		.cfg    (cfg_ch)
	);

	logic [15:0] dt_reg;
	logic [15:0] band_reg;
	update_t     pending_updates[$];
	int          fail_count;
	int          cycle_count;
	int          src_idle_pct;
	int          snk_idle_pct;

	always #(HALF_PERIOD) clk = ~clk;

	// Upwind Hamiltonian, dt*sign*H step and saturation for one point
	function automatic update_t godunov_update(point_t p);
		longint      refv, curv, fx, bx, fy, by, band, h, term, result;
		logic [63:0] a, b, c, d, sq_x, sq_y, sum, root, trial, mag, prod;
		logic        pos;
		update_t     u;
		refv   = p.ref_level;
		curv   = p.cur_level;
		fx     = p.fwd_diff_x;
		bx     = p.back_diff_x;
		fy     = p.fwd_diff_y;
		by     = p.back_diff_y;
		band   = longint'(band_reg);
		result = curv;
		u.saturated = 1'b0;
		if (refv < -band || refv > band) begin
			pos = refv > band;
			// positive side takes negative back parts and positive forward parts
			a = pos ? ((bx < 0) ? -bx : 0) : ((bx > 0) ? bx : 0);
			b = pos ? ((fx > 0) ? fx : 0) : ((fx < 0) ? -fx : 0);
			c = pos ? ((by < 0) ? -by : 0) : ((by > 0) ? by : 0);
			d = pos ? ((fy > 0) ? fy : 0) : ((fy < 0) ? -fy : 0);
			sq_x = (a * a > b * b) ? a * a : b * b;
			sq_y = (c * c > d * d) ? c * c : d * d;
			sum  = sq_x + sq_y;
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= sum)
					root = trial;
			end
			h = $signed(root) - 65536;
			if (h != 0) begin
				mag  = (h < 0) ? -h : h;
				prod = (64'(dt_reg) * mag + 64'd32768) >> 16;
				term = $signed(prod);
				if (h < 0)
					term = -term;
				result = pos ? curv - term : curv + term;
			end
		end
		if (result > SAT_HI) begin
			result = SAT_HI;
			u.saturated = 1'b1;
		end else if (result < SAT_LO) begin
			result = SAT_LO;
			u.saturated = 1'b1;
		end
		u.new_level = result[31:0];
		return u;
	endfunction

	function automatic point_t make_point(logic signed [31:0] rl, logic signed [31:0] cl,
			logic signed [31:0] fx, logic signed [31:0] bx,
			logic signed [31:0] fy, logic signed [31:0] by);
		point_t p;
		p.ref_level   = rl;
		p.cur_level   = cl;
		p.fwd_diff_x  = fx;
		p.back_diff_x = bx;
		p.fwd_diff_y  = fy;
		p.back_diff_y = by;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_value();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6:    v = $signed($urandom_range(0, 393216)) - 196608;
			7, 8:       v = ($urandom_range(1) ? 32'sd65536 : -32'sd65536)
					+ $signed($urandom_range(0, 64)) - 32;
			default: begin
				case ($urandom_range(4))
					0:       v = FIELD_MIN;
					1:       v = FIELD_MAX;
					2:       v = 32'sd0;
					3:       v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] rand_ref();
		int edge_val;
		case ($urandom_range(15))
			0, 1, 2: begin
				edge_val = int'(band_reg) + int'($urandom_range(2)) - 1;
				if ($urandom_range(1))
					edge_val = -edge_val;
				return edge_val;
			end
			3:       return 32'sd0;
			default: return rand_value();
		endcase
	endfunction

	function automatic point_t random_point();
		return make_point(rand_ref(), rand_value(), rand_value(), rand_value(),
			rand_value(), rand_value());
	endfunction

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_point(point_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			pt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pt_ch.valid       <= 1'b1;
		pt_ch.ref_level   <= p.ref_level;
		pt_ch.cur_level   <= p.cur_level;
		pt_ch.fwd_diff_x  <= p.fwd_diff_x;
		pt_ch.back_diff_x <= p.back_diff_x;
		pt_ch.fwd_diff_y  <= p.fwd_diff_y;
		pt_ch.back_diff_y <= p.back_diff_y;
		do @(posedge clk); while (!pt_ch.ready);
		pending_updates.push_back(godunov_update(p));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pt_ch.valid <= 1'b0;
		while (pending_updates.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(lsrgu_pkg::cfg_idx_t idx, logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			lsrgu_pkg::CFG_TIME_STEP: dt_reg = value;
			lsrgu_pkg::CFG_SIGN_BAND: band_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// reset values: dt 655, band 7
	task automatic test_reset_defaults();
		send_point(make_point(32'sd0, 32'sd12345, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN));
		send_point(make_point(32'sd0, FIELD_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_point(make_point(32'sd0, FIELD_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_point(make_point(32'sd7, 32'sd1000, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_point(make_point(-32'sd7, 32'sd1000, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		// unit gradient, H exactly zero
		send_point(make_point(32'sd8, 32'sd5000, 32'sd0, -32'sd65536, 32'sd0, 32'sd0));
		send_point(make_point(32'sd8, 32'sd5000, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_point(make_point(-32'sd8, 32'sd5000, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		// largest radicand
		send_point(make_point(-32'sd8, 32'sd0, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		send_point(make_point(FIELD_MAX, 32'sd0, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_point(make_point(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		send_point(make_point(FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_point(make_point(32'sd8, FIELD_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_point(make_point(-32'sd8, FIELD_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
	endtask

	task automatic test_time_step_max();
		wait_drained();
		write_reg(lsrgu_pkg::CFG_TIME_STEP, 16'hFFFF);
		write_reg(lsrgu_pkg::CFG_SIGN_BAND, 16'h0000);
		send_point(make_point(32'sd1, 32'sd0, 32'sd131072, -32'sd65536, 32'sd0, 32'sd0));
		send_point(make_point(-32'sd1, 32'sd0, -32'sd131072, 32'sd65536, 32'sd0, 32'sd0));
		send_point(make_point(32'sd0, 32'sd77, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_point(make_point(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN));
		send_point(make_point(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
	endtask

	task automatic test_wide_band();
		wait_drained();
		write_reg(lsrgu_pkg::CFG_TIME_STEP, 16'h0000);
		write_reg(lsrgu_pkg::CFG_SIGN_BAND, 16'hFFFF);
		send_point(make_point(32'sd65535, 32'sd9, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_point(make_point(-32'sd65535, 32'sd9, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
		send_point(make_point(32'sd65536, FIELD_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_point(make_point(-32'sd65536, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
	endtask

	task automatic test_random_traffic(int n_items, int src_pct, int snk_pct);
		wait_drained();
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		write_reg(lsrgu_pkg::CFG_TIME_STEP, $urandom_range(3) == 0
			? 16'($urandom_range(0, 1023)) : 16'($urandom_range(0, 65535)));
		write_reg(lsrgu_pkg::CFG_SIGN_BAND, $urandom_range(3) == 0
			? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 15)));
		for (int i = 0; i < n_items; i++) begin
			// hold off until the pipe is empty once per phase
			if (i == n_items / 2)
				wait_drained();
			send_point(random_point());
		end
	endtask

	always @(negedge clk)
		upd_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin : check_updates
		update_t want;
		if (arst_n && upd_ch.valid && upd_ch.ready) begin
			if (pending_updates.size() == 0) begin
				$display("%0t: unexpected update new_level %0d saturated %0b", $time,
					upd_ch.new_level, upd_ch.saturated);
				fail_count++;
			end else begin
				want = pending_updates.pop_front();
				if (upd_ch.new_level !== want.new_level) begin
					$display("%0t: new_level expected %0d got %0d", $time,
						want.new_level, upd_ch.new_level);
					fail_count++;
				end
				if (upd_ch.saturated !== want.saturated) begin
					$display("%0t: saturated expected %0b got %0b", $time,
						want.saturated, upd_ch.saturated);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		fail_count        = 0;
		cycle_count       = 0;
		src_idle_pct      = 17;
		snk_idle_pct      = 70;
		dt_reg            = 16'd655;
		band_reg          = 16'd7;
		pt_ch.valid       = 1'b0;
		pt_ch.ref_level   = '0;
		pt_ch.cur_level   = '0;
		pt_ch.fwd_diff_x  = '0;
		pt_ch.back_diff_x = '0;
		pt_ch.fwd_diff_y  = '0;
		pt_ch.back_diff_y = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = lsrgu_pkg::CFG_TIME_STEP;
		cfg_ch.data       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_time_step_max();
		test_wide_band();
		test_random_traffic(300, 17, 70);
		test_random_traffic(300, 70, 17);
		test_random_traffic(300, 0, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== level_set_reinit_godunov_update.f =====
rtl/lsrgu_pkg.sv
rtl/lsrgu_ifs.sv
rtl/lsrgu_isqrt.sv
rtl/level_set_reinit_godunov_update.sv
tb/sv/tb_top.sv
